[rtl/core/cfbl_pkg.sv]
// ----------------------------------------------------------------------------
// cfbl_pkg: shared definitions for the chained free-block list
// Sizes, command and status codes, sequencer states, the result bundle and
// the chain entry address helper.
// ----------------------------------------------------------------------------
package cfbl_pkg;

  localparam int CACHE_SLOTS = 100;
  // Power of two: a block number wraps into the chain store by its low bits.
  localparam int BLOCK_COUNT = 1024;
  localparam int ENTRY_WORDS = CACHE_SLOTS + 1;

  localparam int BLK_W       = 10;
  localparam int COUNT_W     = $clog2(CACHE_SLOTS + 1);
  localparam int SLOT_AW     = $clog2(CACHE_SLOTS);
  localparam int IDX_W       = $clog2(CACHE_SLOTS + 2);
  localparam int BIDX_W      = $clog2(BLOCK_COUNT);
  localparam int CHAIN_DEPTH = BLOCK_COUNT * ENTRY_WORDS;
  localparam int CHAIN_AW    = $clog2(CHAIN_DEPTH);

  localparam logic CMD_FREE     = 1'b0;
  localparam logic CMD_ALLOC    = 1'b1;
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SPILL,
    ST_REFILL,
    ST_RESP
  } cfbl_state_t;

  typedef struct packed {
    logic               status;
    logic [BLK_W-1:0]   allocated_block;
    logic [COUNT_W-1:0] cached_count;
    logic               modified;
  } cfbl_result_t;

  // First word of a block's chain entry: (block mod BLOCK_COUNT) * ENTRY_WORDS.
  function automatic logic [CHAIN_AW-1:0] entry_base(input logic [BLK_W-1:0] blk);
    logic [BIDX_W-1:0] bidx;
    bidx = BIDX_W'(blk);
    return CHAIN_AW'(bidx) * CHAIN_AW'(ENTRY_WORDS);
  endfunction

endpackage

[rtl/core/chained_free_block_list.sv]
// ----------------------------------------------------------------------------
// chained_free_block_list: chained free-block allocator
// Frees and allocates block numbers through a small slot cache that spills
// into, and refills from, per-block chain entries.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall stays high until its result sits in
// the output register. An allocate pops past any zero entries it meets on
// the way. A free into a full cache copies the cache into the block's chain
// entry, and an allocate that empties the cache refills it from the chain
// entry of the block it hands out; both run one word per cycle through the
// single port of the slot RAM and the chain RAM. The next item is accepted
// as soon as the result has moved into the output register, even while that
// result still waits to be taken. The chain store and slot store are not
// cleared at reset.
module chained_free_block_list (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [cfbl_pkg::BLK_W-1:0]   block_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         status,
  output logic [cfbl_pkg::BLK_W-1:0]   allocated_block,
  output logic [cfbl_pkg::COUNT_W-1:0] cached_count,
  output logic                         modified
);
  import cfbl_pkg::*;

  logic                start;
  logic                busy;
  logic                res_valid;
  logic                res_take;
  cfbl_result_t        res;

  logic                slot_we;
  logic [SLOT_AW-1:0]  slot_addr;
  logic [BLK_W-1:0]    slot_wdata;
  logic [BLK_W-1:0]    slot_rdata;
  logic                chain_we;
  logic [CHAIN_AW-1:0] chain_addr;
  logic [BLK_W-1:0]    chain_wdata;
  logic [BLK_W-1:0]    chain_rdata;

  // Take an item only while the sequencer is idle.
  assign in_stall = busy;
  assign start    = in_valid && !in_stall;

  // Move a result into the output register when it is empty or being drained.
  assign res_take = !out_valid || !out_stall;

  cfbl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .block_number (block_number),
    .busy         (busy),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res),
    .slot_we      (slot_we),
    .slot_addr    (slot_addr),
    .slot_wdata   (slot_wdata),
    .slot_rdata   (slot_rdata),
    .chain_we     (chain_we),
    .chain_addr   (chain_addr),
    .chain_wdata  (chain_wdata),
    .chain_rdata  (chain_rdata)
  );

  // Slot cache: one entry per cached free block number.
  cfbl_ram #(
    .WIDTH (BLK_W),
    .DEPTH (CACHE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .addr  (slot_addr),
    .wdata (slot_wdata),
    .rdata (slot_rdata)
  );

  // Chain store: ENTRY_WORDS words per block (count, then a full cache copy).
  cfbl_ram #(
    .WIDTH (BLK_W),
    .DEPTH (CHAIN_DEPTH)
  ) u_chain_ram (
    .clk   (clk),
    .we    (chain_we),
    .addr  (chain_addr),
    .wdata (chain_wdata),
    .rdata (chain_rdata)
  );

  // Output register: hold the result until the far side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      status          <= res.status;
      allocated_block <= res.allocated_block;
      cached_count    <= res.cached_count;
      modified        <= res.modified;
    end
  end

  // An accepted item keeps the input side stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in progress");

  // The cache never reports more entries than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cached_count <= COUNT_W'(CACHE_SLOTS))
    else $error("cached count above capacity");

  // A failed allocate hands out no block and leaves the cache empty.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_EMPTY |-> allocated_block == '0 && cached_count == '0)
    else $error("failed allocate with block or cached entries");

endmodule

[rtl/core/cfbl_ram.sv]
// ----------------------------------------------------------------------------
// cfbl_ram: single-port RAM
// One access per cycle at one address: every cycle reads, and a write also returns the old word; read data registered.
// ----------------------------------------------------------------------------
module cfbl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/cfbl_ctrl.sv]
// ----------------------------------------------------------------------------
// cfbl_ctrl: allocator sequencer
// Push, pop, spill and refill steps over the slot and chain RAMs, with one
// shared chain address adder (entry base plus word index).
// ----------------------------------------------------------------------------
module cfbl_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           cmd,
  input  logic [cfbl_pkg::BLK_W-1:0]     block_number,
  output logic                           busy,
  output logic                           res_valid,
  input  logic                           res_take,
  output cfbl_pkg::cfbl_result_t         res,
  output logic                           slot_we,
  output logic [cfbl_pkg::SLOT_AW-1:0]   slot_addr,
  output logic [cfbl_pkg::BLK_W-1:0]     slot_wdata,
  input  logic [cfbl_pkg::BLK_W-1:0]     slot_rdata,
  output logic                           chain_we,
  output logic [cfbl_pkg::CHAIN_AW-1:0]  chain_addr,
  output logic [cfbl_pkg::BLK_W-1:0]     chain_wdata,
  input  logic [cfbl_pkg::BLK_W-1:0]     chain_rdata
);
  import cfbl_pkg::*;

  localparam logic [IDX_W-1:0]   SPILL_LAST  = IDX_W'(CACHE_SLOTS);
  localparam logic [IDX_W-1:0]   REFILL_LAST = IDX_W'(CACHE_SLOTS + 1);
  localparam logic [IDX_W-1:0]   IDX_ONE     = IDX_W'(1);
  localparam logic [IDX_W-1:0]   IDX_TWO     = IDX_W'(2);
  localparam logic [COUNT_W-1:0] FULL_COUNT  = COUNT_W'(CACHE_SLOTS);
  localparam logic [BLK_W-1:0]   FULL_WORD   = BLK_W'(CACHE_SLOTS);

  cfbl_state_t         state, state_next;
  logic [COUNT_W-1:0]  count;
  logic                changed;
  logic [IDX_W-1:0]    idx;
  logic [CHAIN_AW-1:0] base;
  logic [BLK_W-1:0]    pend_blk;
  logic                res_status;
  logic [BLK_W-1:0]    res_block;

  logic [COUNT_W-1:0]  count_dec;
  logic [IDX_W-1:0]    idx_m2;
  logic                cache_full;
  logic                count_zero;

  assign count_dec  = count - COUNT_W'(1);
  assign idx_m2     = idx - IDX_TWO;
  assign cache_full = (count >= FULL_COUNT);
  assign count_zero = (count == '0);

  // shared address unit: entry base plus word index
  assign chain_addr = base + CHAIN_AW'(idx);

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_RESP);
  assign res       = '{status: res_status, allocated_block: res_block,
                       cached_count: count, modified: changed};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd == CMD_FREE) begin
            state_next = cache_full ? ST_SPILL : ST_RESP;
          end else begin
            state_next = count_zero ? ST_RESP : ST_POP;
          end
        end
      end
      ST_POP: begin
        if (slot_rdata == '0) begin
          state_next = count_zero ? ST_RESP : ST_POP;
        end else begin
          state_next = count_zero ? ST_REFILL : ST_RESP;
        end
      end
      ST_SPILL:  if (idx == SPILL_LAST) state_next = ST_RESP;
      ST_REFILL: if (idx == REFILL_LAST) state_next = ST_RESP;
      ST_RESP:   if (res_take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    slot_we     = 1'b0;
    slot_addr   = '0;
    slot_wdata  = pend_blk;
    chain_we    = 1'b0;
    chain_wdata = slot_rdata;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd == CMD_FREE) begin
            if (!cache_full) begin
              slot_we    = 1'b1;
              slot_addr  = count[SLOT_AW-1:0];
              slot_wdata = block_number;
            end
          end else if (!count_zero) begin
            slot_addr = count_dec[SLOT_AW-1:0];
          end
        end
      end
      ST_POP: begin
        if (!count_zero) begin
          slot_addr = count_dec[SLOT_AW-1:0];
        end
      end
      ST_SPILL: begin
        // read slot i while writing chain word i, which takes slot i-1 (word 0 takes the count)
        if (idx == SPILL_LAST) begin
          slot_we   = 1'b1;
          slot_addr = '0;
        end else begin
          slot_addr = idx[SLOT_AW-1:0];
        end
        chain_we = 1'b1;
        if (idx == '0) begin
          chain_wdata = BLK_W'(count);
        end
      end
      ST_REFILL: begin
        // chain word k arrives in the cycle after its read and lands in slot k-1
        if (idx >= IDX_TWO) begin
          slot_we    = 1'b1;
          slot_addr  = idx_m2[SLOT_AW-1:0];
          slot_wdata = chain_rdata;
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      changed <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            res_status <= STATUS_DONE;
            res_block  <= '0;
            idx        <= '0;
            if (cmd == CMD_FREE) begin
              changed  <= 1'b1;
              pend_blk <= block_number;
              base     <= entry_base(block_number);
              if (!cache_full) begin
                count <= count + COUNT_W'(1);
              end
            end else if (!count_zero) begin
              count   <= count_dec;
              changed <= 1'b1;
            end else begin
              res_status <= STATUS_EMPTY;
            end
          end
        end
        ST_POP: begin
          if (slot_rdata == '0) begin
            if (count_zero) begin
              res_status <= STATUS_EMPTY;
            end else begin
              count <= count_dec;
            end
          end else begin
            res_block <= slot_rdata;
            base      <= entry_base(slot_rdata);
          end
        end
        ST_SPILL: begin
          idx <= idx + IDX_ONE;
          if (idx == SPILL_LAST) begin
            count <= COUNT_W'(1);
          end
        end
        ST_REFILL: begin
          idx <= idx + IDX_ONE;
          if (idx == IDX_ONE) begin
            count <= (chain_rdata > FULL_WORD) ? FULL_COUNT : COUNT_W'(chain_rdata);
          end
        end
        ST_RESP: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule
